// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ENL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication
`define ENL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ===== rtl/enl_pkg.sv =====
// Shared types and constants of the extended natural ALU.
package enl_pkg;

	localparam int CODE_W    = 64;
	localparam int CMD_W     = 3;
	localparam int MUL_DIGIT = 8;

	localparam logic [CMD_W-1:0] CMD_SUM  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DIFF = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PROD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUOT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REM  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POW  = 3'd5;

	localparam logic REG_INF = 1'b0;
	localparam logic REG_EMP = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_DIV_END,
		S_RPROD,
		S_MUL,
		S_MUL_END,
		S_RDIFF,
		S_PCHK,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_RES_SIMPLE,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_Q_SPECIAL,
		DP_Q_DIV,
		DP_MUL_INIT_LR,
		DP_MUL_INIT_QR,
		DP_MUL_INIT_POW,
		DP_MUL_STEP,
		DP_RES_PROD,
		DP_P_SPECIAL,
		DP_P_PROD,
		DP_RES_DIFF,
		DP_POW_INIT,
		DP_POW_UPD,
		DP_RES_ACC
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             prod_spec;
		logic             any_empty;
		logic             quot_div;
		logic             pow_spec;
		logic             qr_prod_spec;
		logic             mul_last;
		logic             div_last;
		logic             exp_zero;
	} status_t;

endpackage

// ===== rtl/enl_ctrl.sv =====
// Sequencer of the extended natural ALU.
module enl_ctrl
	import enl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output ctrl_t   ctl
);

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_nx = S_EVAL;
			S_EVAL: begin
				unique case (st.cmd)
					CMD_PROD: state_nx = st.prod_spec ? S_DONE : S_MUL;
					CMD_QUOT: state_nx = st.quot_div ? S_DIV : S_DONE;
					CMD_REM: begin
						if (st.any_empty) state_nx = S_DONE;
						else if (st.quot_div) state_nx = S_DIV;
						else state_nx = S_RPROD;
					end
					CMD_POW:  state_nx = st.pow_spec ? S_DONE : S_PCHK;
					default:  state_nx = S_DONE;
				endcase
			end
			S_DIV:     if (st.div_last) state_nx = S_DIV_END;
			S_DIV_END: state_nx = (st.cmd == CMD_REM) ? S_RPROD : S_DONE;
			S_RPROD:   state_nx = st.qr_prod_spec ? S_RDIFF : S_MUL;
			S_MUL:     if (st.mul_last) state_nx = S_MUL_END;
			S_MUL_END: begin
				if (st.cmd == CMD_REM) state_nx = S_RDIFF;
				else if (st.cmd == CMD_POW) state_nx = S_PCHK;
				else state_nx = S_DONE;
			end
			S_RDIFF:   state_nx = S_DONE;
			S_PCHK:    state_nx = st.exp_zero ? S_DONE : S_MUL;
			S_DONE:    if (out_free) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl.op       = DP_NONE;
		ctl.out_load = 1'b0;
		unique case (state_q)
			S_IDLE:    if (in_valid) ctl.op = DP_LOAD;
			S_EVAL: begin
				unique case (st.cmd)
					CMD_PROD: ctl.op = st.prod_spec ? DP_RES_SIMPLE : DP_MUL_INIT_LR;
					CMD_QUOT: ctl.op = st.quot_div ? DP_DIV_INIT : DP_RES_SIMPLE;
					CMD_REM: begin
						if (st.any_empty) ctl.op = DP_RES_SIMPLE;
						else if (st.quot_div) ctl.op = DP_DIV_INIT;
						else ctl.op = DP_Q_SPECIAL;
					end
					CMD_POW:  ctl.op = st.pow_spec ? DP_RES_SIMPLE : DP_POW_INIT;
					default:  ctl.op = DP_RES_SIMPLE;
				endcase
			end
			S_DIV:     ctl.op = DP_DIV_STEP;
			S_DIV_END: ctl.op = DP_Q_DIV;
			S_RPROD:   ctl.op = st.qr_prod_spec ? DP_P_SPECIAL : DP_MUL_INIT_QR;
			S_MUL:     ctl.op = DP_MUL_STEP;
			S_MUL_END: begin
				if (st.cmd == CMD_REM) ctl.op = DP_P_PROD;
				else if (st.cmd == CMD_POW) ctl.op = DP_POW_UPD;
				else ctl.op = DP_RES_PROD;
			end
			S_RDIFF:   ctl.op = DP_RES_DIFF;
			S_PCHK:    ctl.op = st.exp_zero ? DP_RES_ACC : DP_MUL_INIT_POW;
			S_DONE:    ctl.out_load = out_free;
			default:   ctl.op = DP_NONE;
		endcase
	end

endmodule

// ===== rtl/enl_dp.sv =====
// Datapath of the extended natural ALU: code registers, rules, divider, multipliers.
module enl_dp
	import enl_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [CODE_W-1:0]     cfg_data,
	input  logic [CMD_W-1:0]      command,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic [VALUE_BITS-1:0] result_value,
	input  ctrl_t                 ctl,
	output status_t               st
);

	localparam int W    = VALUE_BITS;
	localparam int MDIG = (W + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int MCW  = (MDIG > 1) ? $clog2(MDIG) : 1;
	localparam int DCW  = $clog2(W);

	typedef logic [W-1:0] val_t;

	logic [CODE_W-1:0] inf_q, emp_q;
	logic [CMD_W-1:0]  cmd_q;
	val_t l_q, r_q, q_q, p_q, res_q, out_q;
	val_t ax_q, ay_q, ap_q, bx_q, by_q, bp_q;
	val_t rem_q, dq_q, acc_q, base_q, exp_q;
	logic [MCW-1:0] mcnt_q;
	logic [DCW-1:0] dcnt_q;

	val_t inf_v, emp_v;
	logic l_inf, r_inf, l_emp, r_emp, q_inf, q_emp, p_inf, p_emp;
	val_t simple_res, quot_res, pow_res;
	logic [W+MUL_DIGIT-1:0] a_pp, b_pp;
	logic [W:0] div_sh, div_tr;

	assign inf_v = inf_q[W-1:0];
	assign emp_v = emp_q[W-1:0];
	assign l_inf = (l_q == inf_v);
	assign r_inf = (r_q == inf_v);
	assign q_inf = (q_q == inf_v);
	assign p_inf = (p_q == inf_v);
	assign l_emp = (l_q == emp_v);
	assign r_emp = (r_q == emp_v);
	assign q_emp = (q_q == emp_v);
	assign p_emp = (p_q == emp_v);

	function automatic val_t diff_rule(input val_t a, input val_t b, input logic ae,
		input logic be, input logic ai, input logic bi, input val_t inf);
		val_t r;
		if (ae || be) r = a;
		else if (ai || bi) r = (a == b) ? '0 : inf;
		else r = (a > b) ? (a - b) : (b - a);
		return r;
	endfunction

	// only for operands where one side is a reserved code
	function automatic val_t prod_rule(input val_t a, input val_t b, input logic ae,
		input logic be, input val_t inf);
		val_t r;
		if (ae || be) r = a;
		else r = (a == '0 || b == '0) ? '0 : inf;
		return r;
	endfunction

	always_comb begin
		if (l_emp || r_emp) quot_res = l_q;
		else if (r_q == '0) quot_res = inf_v;
		else if (r_inf) quot_res = l_inf ? val_t'(1) : '0;
		else if (l_inf) quot_res = l_q;
		else quot_res = '0;
	end

	always_comb begin
		if (l_emp || l_inf || r_emp) pow_res = l_q;
		else if (r_inf) pow_res = (l_q == '0) ? l_q : inf_v;
		else pow_res = val_t'(1);
	end

	always_comb begin
		case (cmd_q)
			CMD_SUM: begin
				if (l_emp || r_emp) simple_res = l_q;
				else if (l_inf || r_inf) simple_res = inf_v;
				else simple_res = l_q + r_q;
			end
			CMD_DIFF: simple_res = diff_rule(l_q, r_q, l_emp, r_emp, l_inf, r_inf, inf_v);
			CMD_PROD: simple_res = prod_rule(l_q, r_q, l_emp, r_emp, inf_v);
			CMD_QUOT: simple_res = quot_res;
			CMD_POW:  simple_res = pow_res;
			default:  simple_res = l_q;
		endcase
	end

	assign st.cmd          = cmd_q;
	assign st.prod_spec    = l_emp || r_emp || l_inf || r_inf;
	assign st.any_empty    = l_emp || r_emp;
	assign st.quot_div     = !(l_emp || r_emp) && (r_q != '0) && !r_inf && !l_inf
		&& !(r_q > l_q);
	assign st.pow_spec     = l_emp || l_inf || r_emp || r_inf || (r_q == '0);
	assign st.qr_prod_spec = q_emp || r_emp || q_inf || r_inf;
	assign st.mul_last     = (mcnt_q == MCW'(MDIG - 1));
	assign st.div_last     = (dcnt_q == DCW'(W - 1));
	assign st.exp_zero     = (exp_q == '0);

	// one digit of each multiplier per cycle
	assign a_pp = ax_q * ay_q[MUL_DIGIT-1:0];
	assign b_pp = bx_q * by_q[MUL_DIGIT-1:0];

	// restoring division, one quotient bit per cycle
	assign div_sh = {rem_q, dq_q[W-1]};
	assign div_tr = div_sh - {1'b0, r_q};

	assign result_value = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= '1;
			emp_q <= {{(CODE_W-1){1'b1}}, 1'b0};
		end else if (cfg_valid) begin
			if (cfg_index == REG_INF) inf_q <= cfg_data;
			else if (cfg_index == REG_EMP) emp_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) out_q <= res_q;
		case (ctl.op)
			DP_LOAD: begin
				cmd_q <= command;
				l_q   <= left_value;
				r_q   <= right_value;
			end
			DP_RES_SIMPLE: res_q <= simple_res;
			DP_DIV_INIT: begin
				rem_q  <= '0;
				dq_q   <= l_q;
				dcnt_q <= '0;
			end
			DP_DIV_STEP: begin
				if (!div_tr[W]) rem_q <= div_tr[W-1:0];
				else rem_q <= div_sh[W-1:0];
				dq_q   <= {dq_q[W-2:0], !div_tr[W]};
				dcnt_q <= dcnt_q + 1'b1;
			end
			DP_Q_SPECIAL: q_q <= quot_res;
			DP_Q_DIV: begin
				q_q   <= dq_q;
				res_q <= dq_q;
			end
			DP_MUL_INIT_LR, DP_MUL_INIT_QR, DP_MUL_INIT_POW: begin
				ap_q   <= '0;
				bp_q   <= '0;
				mcnt_q <= '0;
				bx_q   <= base_q;
				by_q   <= base_q;
				if (ctl.op == DP_MUL_INIT_LR) begin
					ax_q <= l_q;
					ay_q <= r_q;
				end else if (ctl.op == DP_MUL_INIT_QR) begin
					ax_q <= q_q;
					ay_q <= r_q;
				end else begin
					ax_q <= acc_q;
					ay_q <= exp_q[0] ? base_q : val_t'(1);
				end
			end
			DP_MUL_STEP: begin
				ap_q   <= ap_q + a_pp[W-1:0];
				bp_q   <= bp_q + b_pp[W-1:0];
				ax_q   <= ax_q << MUL_DIGIT;
				bx_q   <= bx_q << MUL_DIGIT;
				ay_q   <= ay_q >> MUL_DIGIT;
				by_q   <= by_q >> MUL_DIGIT;
				mcnt_q <= mcnt_q + 1'b1;
			end
			DP_RES_PROD:  res_q <= ap_q;
			DP_P_SPECIAL: p_q <= prod_rule(q_q, r_q, q_emp, r_emp, inf_v);
			DP_P_PROD:    p_q <= ap_q;
			DP_RES_DIFF:  res_q <= diff_rule(l_q, p_q, l_emp, p_emp, l_inf, p_inf, inf_v);
			DP_POW_INIT: begin
				acc_q  <= val_t'(1);
				base_q <= l_q;
				exp_q  <= r_q;
			end
			DP_POW_UPD: begin
				acc_q  <= ap_q;
				base_q <= bp_q;
				exp_q  <= exp_q >> 1;
			end
			DP_RES_ACC: res_q <= acc_q;
			default: ;
		endcase
	end

endmodule

// ===== rtl/extended_natural_alu_unit.sv =====
// Top level of the extended natural ALU.
//
// Arithmetic on VALUE_BITS-wide naturals where two programmable codes stand
// for infinity and for the empty set. One word in, one word out.
// Channels: input word (command, left_value, right_value) on in_valid /
// in_ready; result word (result_value) on out_valid / out_ready; code
// registers on cfg_valid / cfg_ready with cfg_index 0 = infinity code,
// 1 = empty code. cfg_ready is always high; write codes only while idle.
// Sum, difference and the reserved-code cases take their result from the
// rules alone. Product runs the multipliers, quotient the divider, and
// remainder the divider or quotient rules, then the multipliers or product
// rules, then the difference rule; power runs one multiplier pass per bit
// of the exponent until the exponent is used up.
// Division runs one quotient bit per cycle; multiplication runs one 8-bit
// digit per cycle on two shared multipliers (power squares and multiplies
// at once). One word is in work at a time; the next is taken once the
// result has moved into the output register, which may still be waiting.
// Reset restores the codes to all ones and all ones minus one and empties
// the output register. A stalled receiver holds result_value steady and
// blocks the block once a second result is ready.
module extended_natural_alu_unit
	import enl_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] result_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CODE_W-1:0]     cfg_data
);

	ctrl_t   ctl;
	status_t st;

	assign cfg_ready = 1'b1;

	// sequencer: owns handshakes and the output valid flag
	enl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.ctl       (ctl)
	);

	// datapath: operands, code registers, divider, multipliers, output register
	enl_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.left_value   (left_value),
		.right_value  (right_value),
		.result_value (result_value),
		.ctl          (ctl),
		.st           (st)
	);

endmodule

// ===== rtl/enl_checker.sv =====
// Port-level checks for the extended natural ALU, bound to the top level.
`include "assert_macros.svh"

module enl_checker
	import enl_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [CMD_W-1:0]      command,
	input logic [VALUE_BITS-1:0] left_value,
	input logic [VALUE_BITS-1:0] right_value,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] result_value,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  cfg_index,
	input logic [CODE_W-1:0]     cfg_data
);

	// a stalled result keeps its value
	`ENL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value))
	// one word in work at a time
	`ENL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// code port never back-pressures
	`ENL_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind extended_natural_alu_unit enl_checker #(.VALUE_BITS(VALUE_BITS)) u_enl_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the extended natural ALU.
`timescale 1ns / 1ps

module tb;
	import enl_pkg::*;

	localparam int VB = 64;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [VB-1:0]    lv;
		logic [VB-1:0]    rv;
	} alu_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = '0;
	logic [VB-1:0] left_value = '0;
	logic [VB-1:0] right_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VB-1:0] result_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_INF;
	logic [CODE_W-1:0] cfg_data = '0;

	extended_natural_alu_unit #(.VALUE_BITS(VB)) u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Local copy of the code registers, updated when a write is accepted.
	logic [VB-1:0] inf_code = '1;
	logic [VB-1:0] emp_code = {{(VB-1){1'b1}}, 1'b0};

	alu_word_t      pending_words[$];
	logic [VB-1:0]  expected_results[$];
	int err_count = 0;
	int words_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;

	// Stall controls: idle_free turns off random gaps; rx_hold blocks the receiver.
	bit idle_free = 1'b0;
	bit rx_hold = 1'b0;

	function automatic bit is_inf(logic [VB-1:0] v);
		return v == inf_code;
	endfunction

	function automatic bit is_emp(logic [VB-1:0] v);
		return v == emp_code;
	endfunction

	function automatic logic [VB-1:0] calc_diff(logic [VB-1:0] l, logic [VB-1:0] r);
		if (is_emp(l) || is_emp(r)) return l;
		if (is_inf(l) || is_inf(r)) return (l == r) ? '0 : inf_code;
		return (l > r) ? l - r : r - l;
	endfunction

	function automatic logic [VB-1:0] calc_prod(logic [VB-1:0] l, logic [VB-1:0] r);
		if (is_emp(l) || is_emp(r)) return l;
		if (is_inf(l) || is_inf(r)) return (l == 0 || r == 0) ? '0 : inf_code;
		return l * r;
	endfunction

	function automatic logic [VB-1:0] calc_quot(logic [VB-1:0] l, logic [VB-1:0] r);
		if (is_emp(l) || is_emp(r)) return l;
		if (r == 0) return inf_code;
		if (is_inf(r)) return is_inf(l) ? VB'(1) : '0;
		if (is_inf(l)) return l;
		return l / r;
	endfunction

	function automatic logic [VB-1:0] calc_pow(logic [VB-1:0] l, logic [VB-1:0] r);
		logic [VB-1:0] acc, b, e;
		acc = VB'(1);
		b = l;
		e = r;
		if (is_emp(l) || is_inf(l) || is_emp(r)) return l;
		if (is_inf(r)) return (l == 0) ? l : inf_code;
		while (e != 0) begin
			if (e[0]) acc = acc * b;
			b = b * b;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic [VB-1:0] alu_result(alu_word_t w);
		case (w.cmd)
			CMD_SUM: begin
				if (is_emp(w.lv) || is_emp(w.rv)) return w.lv;
				if (is_inf(w.lv) || is_inf(w.rv)) return inf_code;
				return w.lv + w.rv;
			end
			CMD_DIFF: return calc_diff(w.lv, w.rv);
			CMD_PROD: return calc_prod(w.lv, w.rv);
			CMD_QUOT: return calc_quot(w.lv, w.rv);
			CMD_REM: begin
				if (is_emp(w.lv) || is_emp(w.rv)) return w.lv;
				return calc_diff(w.lv, calc_prod(calc_quot(w.lv, w.rv), w.rv));
			end
			CMD_POW: return calc_pow(w.lv, w.rv);
			default: return w.lv;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [VB-1:0] got, logic [VB-1:0] want);
		err_count++;
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// Driver: holds the word until accepted, then maybe pulls the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid) begin
					expected_results.push_back(alu_result('{command, left_value, right_value}));
					words_sent++;
				end
				if (pending_words.size() > 0 && (idle_free || $urandom_range(99) >= 21)) begin
					alu_word_t w;
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					command <= w.cmd;
					left_value <= w.lv;
					right_value <= w.rv;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_INF) inf_code <= cfg_data;
				else emp_code <= cfg_data;
			end
		end
	end

	// Monitor: checks every accepted result and decides the next ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0)
					report_mismatch("unexpected word", result_value, '0);
				else begin
					logic [VB-1:0] want;
					want = expected_results.pop_front();
					if (result_value !== want)
						report_mismatch("result_value", result_value, want);
				end
			end
			out_ready <= !rx_hold && (idle_free || $urandom_range(99) >= 21);
		end
	end

	function automatic logic [VB-1:0] pick_value();
		case ($urandom_range(9))
			0: return inf_code;
			1: return emp_code;
			2: return '0;
			3: return VB'($urandom_range(3));
			4: return {$urandom, $urandom};
			5: return VB'($urandom_range(1000));
			6: return inf_code ^ VB'(1);
			7: return {32'h0, $urandom};
			default: return {$urandom, $urandom} >> $urandom_range(63);
		endcase
	endfunction

	function automatic alu_word_t rand_word();
		alu_word_t w;
		w.cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(7, 6))
			: CMD_W'($urandom_range(5));
		w.lv = pick_value();
		w.rv = pick_value();
		if (w.cmd == CMD_POW && $urandom_range(1)) w.rv = VB'($urandom_range(70));
		return w;
	endfunction

	task automatic queue_word(logic [CMD_W-1:0] c, logic [VB-1:0] l, logic [VB-1:0] r);
		pending_words.push_back('{c, l, r});
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (150) @(posedge clk);
	endtask

	// Register write while idle.
	task automatic write_code(logic idx, logic [CODE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic random_batch(int n);
		repeat (n) pending_words.push_back(rand_word());
	endtask

	// Main sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, all commands, special cases under reset codes.
		for (int c = 0; c < 8; c++) queue_word(CMD_W'(c), 64'd100, 64'd7);
		queue_word(CMD_SUM, inf_code, 64'd5);
		queue_word(CMD_SUM, '1 - 64'd3, 64'd3);          // sum lands exactly on a code
		queue_word(CMD_DIFF, inf_code, inf_code);
		queue_word(CMD_DIFF, emp_code, inf_code);
		queue_word(CMD_PROD, inf_code, 64'd0);
		queue_word(CMD_PROD, 64'h8000_0000_0000_0001, 64'd3);
		queue_word(CMD_QUOT, 64'd9, 64'd0);
		queue_word(CMD_QUOT, inf_code, inf_code);
		queue_word(CMD_QUOT, inf_code, 64'd4);
		queue_word(CMD_REM, 64'hFFFF_FFFF_FFFF_FFFD, 64'd10);
		queue_word(CMD_REM, 64'd5, 64'd0);
		queue_word(CMD_POW, 64'd2, 64'd64);               // large power gives 0
		queue_word(CMD_POW, 64'd0, inf_code);
		queue_word(CMD_POW, 64'd3, 64'd0);
		queue_word(CMD_POW, 64'd3, 64'hFFFF_FFFF_FFFF_FFFD);
		queue_word(CMD_POW, inf_code, 64'd2);
		queue_word(CMD_DIFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFD);
		drain();

		random_batch(300);
		drain();

		// Receiver blocked for a long stretch while the sender keeps offering.
		random_batch(40);
		rx_hold = 1'b1;
		repeat (3000) @(posedge clk);
		rx_hold = 1'b0;
		drain();

		// Small codes, including zero.
		write_code(REG_INF, 64'd0);
		write_code(REG_EMP, 64'd1);
		random_batch(150);
		drain();

		// Coinciding codes: empty wins.
		write_code(REG_INF, 64'd5);
		write_code(REG_EMP, 64'd5);
		random_batch(150);
		drain();

		// Swapped extremes, then a stretch with no idling at all.
		write_code(REG_INF, '1 - 64'd1);
		write_code(REG_EMP, '1);
		idle_free = 1'b1;
		random_batch(150);
		drain();
		idle_free = 1'b0;

		write_code(REG_INF, {$urandom, $urandom});
		write_code(REG_EMP, {$urandom, $urandom});
		random_batch(150);
		drain();

		write_code(REG_INF, '1);
		write_code(REG_EMP, '1 - 64'd1);
		random_batch(100);
		drain();

		$display("Covered %0d words, %0d results, %0d code writes over six code settings.",
			words_sent, results_seen, cfg_writes);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("Timeout after %0t", $realtime);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
